@@ hdl/tmsr_pkg.sv @@
// ----------------------------------------------------------------------------
// Thumb move/status unit package
// Operation and status codes, the decoded item that crosses from the decode
// front to the execute back, and the APSR view helper.
// ----------------------------------------------------------------------------
package tmsr_pkg;

  // Pre-classified instruction encodings
  typedef enum logic [2:0] {
    OP_MRS_T1     = 3'd0,
    OP_MSR_T1     = 3'd1,
    OP_MOV_IMM_T1 = 3'd2,
    OP_MOV_IMM_T2 = 3'd3,
    OP_MOV_IMM_T3 = 3'd4,
    OP_MOV_REG_T1 = 3'd5,
    OP_MOV_REG_T2 = 3'd6,
    OP_MOV_REG_T3 = 3'd7
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    STS_DONE     = 2'd0,
    STS_UNPRED   = 2'd1,
    STS_NOT_IMPL = 2'd2
  } status_t;

  localparam logic [3:0] REG_SP = 4'd13;
  localparam logic [3:0] REG_PC = 4'd15;

  localparam logic [31:0] APSR_NZCVQ_MASK = 32'hf800_0000;
  localparam logic [31:0] APSR_GE_MASK    = 32'h000f_0000;

  // Flag word layout: 8 N, 7 Z, 6 C, 5 V, 4 Q, 3:0 GE
  localparam int FLAG_W = 9;

  // Decoded item; everything here is independent of architectural state
  typedef struct packed {
    status_t     status;     // status known at decode
    logic        wr_en;      // writes rd when status stays done
    logic [3:0]  rd;
    logic        src_reg;    // value comes from the register file
    logic [3:0]  src_idx;
    logic [31:0] imm;        // immediate, PC value or IPSR part
    logic        set_nzc;    // S form flag update
    logic        carry_sel;  // take carry from the immediate expansion
    logic        carry_val;
    logic        msr_flags;  // MSR writing APSR fields
    logic [1:0]  msr_mask;
    logic        mrs_apsr;   // MRS merges APSR bits
  } dec_t;

  // Architectural APSR view of the flag word
  function automatic logic [31:0] apsr_view(input logic [FLAG_W-1:0] flags);
    apsr_view = {flags[8:4], 7'd0, flags[3:0], 16'd0};
  endfunction

endpackage

@@ hdl/tmsr_front.sv @@
// ----------------------------------------------------------------------------
// Thumb move/status unit decode front
// Extracts fields, expands modified immediates, resolves PC reads and
// classifies every state-independent unpredictable or unimplemented case.
// ----------------------------------------------------------------------------
module tmsr_front (
  input  tmsr_pkg::op_t  operation,
  input  logic [31:0]    instruction,
  input  logic           in_it_block,
  input  logic           last_in_it_block,
  input  logic [8:0]     exception_number,
  input  logic [31:0]    pc_value,
  output tmsr_pkg::dec_t dec
);
  import tmsr_pkg::*;

  logic [7:0]  sysm;
  logic [1:0]  mask;
  logic [11:0] imm12;
  logic [7:0]  ib;
  logic        sysm_ok;
  logic [31:0] rep_val;
  logic [31:0] rot_src;
  logic [63:0] rot_dbl;
  logic [31:0] exp_val;
  logic        exp_rot;
  logic        exp_bad;

  // Field extraction and modified immediate expansion
  always_comb begin
    sysm    = instruction[7:0];
    mask    = instruction[11:10];
    imm12   = {instruction[26], instruction[14:12], instruction[7:0]};
    ib      = imm12[7:0];
    sysm_ok = sysm inside {[8'd0:8'd3], [8'd5:8'd9], [8'd16:8'd20]};
    case (imm12[9:8])
      2'd0:    rep_val = {24'd0, ib};
      2'd1:    rep_val = {8'd0, ib, 8'd0, ib};
      2'd2:    rep_val = {ib, 8'd0, ib, 8'd0};
      2'd3:    rep_val = {ib, ib, ib, ib};
      default: rep_val = '0;
    endcase
    rot_src = {24'd0, 1'b1, imm12[6:0]};
    rot_dbl = {rot_src, rot_src} >> imm12[11:7];
    exp_rot = (imm12[11:10] != 2'd0);
    exp_val = exp_rot ? rot_dbl[31:0] : rep_val;
    exp_bad = !exp_rot && (imm12[9:8] != 2'd0) && (ib == 8'd0);
  end

  logic       use_rm;
  logic [3:0] rm;
  logic       s_bit;

  // Classify per encoding
  always_comb begin
    dec    = '0;
    dec.status = STS_DONE;
    use_rm = 1'b0;
    rm     = '0;
    s_bit  = instruction[20];
    case (operation)
      OP_MRS_T1: begin
        dec.rd       = instruction[11:8];
        dec.imm      = sysm[0] ? {23'd0, exception_number} : 32'd0;
        dec.mrs_apsr = !sysm[2];
        if (dec.rd == REG_SP || dec.rd == REG_PC || !sysm_ok) begin
          dec.status = STS_UNPRED;
        end else if (sysm >= 8'd8) begin
          dec.status = STS_NOT_IMPL;
        end else begin
          dec.wr_en = 1'b1;
        end
      end
      OP_MSR_T1: begin
        use_rm       = 1'b1;
        rm           = instruction[19:16];
        dec.msr_mask = mask;
        if (mask == 2'd0 || (mask != 2'd2 && sysm > 8'd3)) begin
          dec.status = STS_UNPRED;
        end else if (rm == REG_SP || rm == REG_PC || !sysm_ok) begin
          dec.status = STS_UNPRED;
        end else if (sysm >= 8'd8) begin
          dec.status = STS_NOT_IMPL;
        end else begin
          dec.msr_flags = !sysm[2];
        end
      end
      OP_MOV_IMM_T1: begin
        dec.rd      = {1'b0, instruction[10:8]};
        dec.imm     = {24'd0, instruction[7:0]};
        dec.wr_en   = 1'b1;
        dec.set_nzc = !in_it_block;
      end
      OP_MOV_IMM_T2: begin
        dec.rd        = instruction[11:8];
        dec.imm       = exp_val;
        dec.carry_sel = exp_rot;
        dec.carry_val = exp_val[31];
        if (exp_bad || dec.rd == REG_SP || dec.rd == REG_PC) begin
          dec.status = STS_UNPRED;
        end else begin
          dec.wr_en   = 1'b1;
          dec.set_nzc = s_bit;
        end
      end
      OP_MOV_IMM_T3: begin
        dec.rd  = instruction[11:8];
        dec.imm = {16'd0, instruction[19:16], instruction[26], instruction[14:12],
                   instruction[7:0]};
        if (dec.rd == REG_SP || dec.rd == REG_PC) begin
          dec.status = STS_UNPRED;
        end else begin
          dec.wr_en = 1'b1;
        end
      end
      OP_MOV_REG_T1: begin
        use_rm = 1'b1;
        rm     = instruction[6:3];
        dec.rd = {instruction[7], instruction[2:0]};
        if (dec.rd == REG_PC && in_it_block && !last_in_it_block) begin
          dec.status = STS_UNPRED;
        end else if (dec.rd == REG_PC) begin
          dec.status = STS_NOT_IMPL;
        end else begin
          dec.wr_en = 1'b1;
        end
      end
      OP_MOV_REG_T2: begin
        use_rm = 1'b1;
        rm     = {1'b0, instruction[5:3]};
        dec.rd = {1'b0, instruction[2:0]};
        if (in_it_block) begin
          dec.status = STS_UNPRED;
        end else begin
          dec.wr_en   = 1'b1;
          dec.set_nzc = 1'b1;
        end
      end
      OP_MOV_REG_T3: begin
        use_rm = 1'b1;
        rm     = instruction[3:0];
        dec.rd = instruction[11:8];
        if (s_bit && (dec.rd == REG_SP || dec.rd == REG_PC ||
                      rm == REG_SP || rm == REG_PC)) begin
          dec.status = STS_UNPRED;
        end else if (!s_bit && (dec.rd == REG_PC || rm == REG_PC ||
                                (dec.rd == REG_SP && rm == REG_SP))) begin
          dec.status = STS_UNPRED;
        end else begin
          dec.wr_en   = 1'b1;
          dec.set_nzc = s_bit;
        end
      end
      default: begin
        dec.status = STS_NOT_IMPL;
      end
    endcase

    // Resolve the source register; r15 reads the PC of this item
    if (use_rm) begin
      if (rm == REG_PC) begin
        dec.imm = pc_value;
      end else begin
        dec.src_reg = 1'b1;
        dec.src_idx = rm;
      end
    end
  end

endmodule

@@ hdl/tmsr_queue.sv @@
// ----------------------------------------------------------------------------
// Thumb move/status unit decode queue
// Two-entry FIFO of decoded items between the decode front and the execute
// back, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module tmsr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  tmsr_pkg::dec_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output tmsr_pkg::dec_t pop_data
);
  import tmsr_pkg::*;

  dec_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hdl/tmsr_back.sv @@
// ----------------------------------------------------------------------------
// Thumb move/status unit execute back
// Reads the register file, applies flag and GE rules, updates the register
// file and APSR flags, and holds the result in an output register.
// ----------------------------------------------------------------------------
module tmsr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           dsp_extension,
  input  logic           dec_valid,
  output logic           dec_ready,
  input  tmsr_pkg::dec_t dec,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_status,
  output logic           out_reg_write,
  output logic [3:0]     out_reg_index,
  output logic [31:0]    out_reg_value,
  output logic           out_flags_written,
  output logic [31:0]    out_apsr_value
);
  import tmsr_pkg::*;

  logic [31:0]       rf_r [16];
  logic [FLAG_W-1:0] flags_r, flags_nxt;

  logic              out_valid_r;
  logic [1:0]        status_r;
  logic              reg_write_r;
  logic [3:0]        reg_index_r;
  logic [31:0]       reg_value_r;
  logic              flags_written_r;
  logic [31:0]       apsr_value_r;

  logic              fire;
  status_t           status;
  logic              ok;
  logic              wr;
  logic              fw;
  logic [31:0]       src_val;
  logic [31:0]       val;
  logic [31:0]       view;
  logic              carry;

  assign dec_ready = !out_valid_r || out_ready;
  assign fire      = dec_valid && dec_ready;

  // Execute one decoded item against the current state
  always_comb begin
    view    = apsr_view(flags_r);
    src_val = dec.src_reg ? rf_r[dec.src_idx] : dec.imm;
    val     = src_val;
    if (dec.mrs_apsr) begin
      val = dec.imm | (view & APSR_NZCVQ_MASK) |
            (dsp_extension ? (view & APSR_GE_MASK) : 32'd0);
    end
    status = dec.status;
    if (dec.status == STS_DONE && dec.msr_flags && dec.msr_mask[0] && !dsp_extension) begin
      status = STS_UNPRED;
    end
    ok    = (status == STS_DONE);
    wr    = ok && dec.wr_en;
    fw    = ok && (dec.set_nzc || dec.msr_flags);
    carry = dec.carry_sel ? dec.carry_val : flags_r[6];

    flags_nxt = flags_r;
    if (dec.set_nzc) begin
      flags_nxt[8] = val[31];
      flags_nxt[7] = (val == 32'd0);
      flags_nxt[6] = carry;
    end
    if (dec.msr_flags) begin
      if (dec.msr_mask[0]) begin
        flags_nxt[3:0] = src_val[19:16];
      end
      if (dec.msr_mask[1]) begin
        flags_nxt[8:5] = src_val[31:28];
      end
    end
  end

  // Commit architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      for (int i = 0; i < 16; i++) begin
        rf_r[i] <= '0;
      end
    end else if (fire) begin
      if (wr) begin
        rf_r[dec.rd] <= val;
      end
      if (fw) begin
        flags_r <= flags_nxt;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dec_ready) begin
      out_valid_r <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r        <= status;
      reg_write_r     <= wr;
      reg_index_r     <= wr ? dec.rd : 4'd0;
      reg_value_r     <= wr ? val : 32'd0;
      flags_written_r <= fw;
      apsr_value_r    <= apsr_view(fw ? flags_nxt : flags_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_reg_write     = reg_write_r;
  assign out_reg_index     = reg_index_r;
  assign out_reg_value     = reg_value_r;
  assign out_flags_written = flags_written_r;
  assign out_apsr_value    = apsr_value_r;

endmodule

@@ hdl/thumb_move_and_status_register_unit.sv @@
// Path: an accepted item is decoded into the queue at acceptance, then executed into the
//   output register when the execute back takes it from the queue.
// Throughput: one item per cycle while results are taken; the execute back reads and writes
//   the register file and flags as it takes each item, so each item sees the one before.
// Reset: register file, APSR flags and DSP option clear; queue and output empty.
// ----------------------------------------------------------------------------
// Thumb move/status register unit
// Executes pre-classified Thumb MOV, MOVW, MRS and MSR instructions against a
// 16-entry register file and the APSR flags, one result per instruction.
// ----------------------------------------------------------------------------
module thumb_move_and_status_register_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_instruction,
  input  logic        in_in_it_block,
  input  logic        in_last_in_it_block,
  input  logic [8:0]  in_exception_number,
  input  logic [31:0] in_pc_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_reg_write,
  output logic [3:0]  out_reg_index,
  output logic [31:0] out_reg_value,
  output logic        out_flags_written,
  output logic [31:0] out_apsr_value
);
  import tmsr_pkg::*;

  logic dsp_r;
  dec_t front_dec;
  dec_t q_dec;
  logic q_valid;
  logic q_ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dsp_r <= 1'b0;
    end else if (cfg_we) begin
      dsp_r <= cfg_wdata;
    end
  end

  tmsr_front u_front (
    .operation        (op_t'(in_operation)),
    .instruction      (in_instruction),
    .in_it_block      (in_in_it_block),
    .last_in_it_block (in_last_in_it_block),
    .exception_number (in_exception_number),
    .pc_value         (in_pc_value),
    .dec              (front_dec)
  );

  tmsr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (front_dec),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_dec)
  );

  tmsr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .dsp_extension     (dsp_r),
    .dec_valid         (q_valid),
    .dec_ready         (q_ready),
    .dec               (q_dec),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_reg_write     (out_reg_write),
    .out_reg_index     (out_reg_index),
    .out_reg_value     (out_reg_value),
    .out_flags_written (out_flags_written),
    .out_apsr_value    (out_apsr_value)
  );

endmodule

@@ sim/move_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Move/status unit result checker
// Watches the configuration write, the instruction channel and the result
// channel. Keeps its own register file, flag word and DSP option, predicts
// the result of every accepted instruction, and compares each accepted
// result against the oldest prediction.
// ----------------------------------------------------------------------------
module move_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_instruction,
  input  logic        in_in_it_block,
  input  logic        in_last_in_it_block,
  input  logic [8:0]  in_exception_number,
  input  logic [31:0] in_pc_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic        out_reg_write,
  input  logic [3:0]  out_reg_index,
  input  logic [31:0] out_reg_value,
  input  logic        out_flags_written,
  input  logic [31:0] out_apsr_value,
  output int          mismatches,
  output int          outstanding
);
  import tmsr_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic        reg_write;
    logic [3:0]  reg_index;
    logic [31:0] reg_value;
    logic        flags_written;
    logic [31:0] apsr_value;
  } move_result_t;

  // Architectural state as the unit should hold it
  logic [31:0]  core_regs [16];
  logic [8:0]   flag_word;      // 8 N, 7 Z, 6 C, 5 V, 4 Q, 3:0 GE
  logic         dsp_present;
  move_result_t expected_results [$];
  move_result_t got, want;

  function automatic logic [31:0] flag_view(input logic [8:0] f);
    return {f[8:4], 7'd0, f[3:0], 16'd0};
  endfunction

  function automatic logic [31:0] read_src(input logic [3:0] r, input logic [31:0] pc);
    return (r == REG_PC) ? pc : core_regs[r];
  endfunction

  function automatic logic is_sp_or_pc(input logic [3:0] r);
    return (r == REG_SP) || (r == REG_PC);
  endfunction

  function automatic logic sysm_ok(input logic [7:0] s);
    return (s <= 8'd3) || (s >= 8'd5 && s <= 8'd9) || (s >= 8'd16 && s <= 8'd20);
  endfunction

  function automatic logic [8:0] nzc_update(input logic [8:0] f, input logic [31:0] v,
                                            input logic c);
    return {v[31], v == 32'd0, c, f[5:0]};
  endfunction

  // Execute one instruction against the local state and return its result
  function automatic move_result_t execute_move(input op_t op, input logic [31:0] w,
                                                input logic in_it, input logic last_it,
                                                input logic [8:0] excn,
                                                input logic [31:0] pc);
    move_result_t r;
    logic [1:0]  sts;
    logic        wr, fw, c, co, zero_pattern, s_form;
    logic [3:0]  rd, rn, rm;
    logic [7:0]  sysm, b;
    logic [1:0]  mask;
    logic [31:0] val, src, rot_base;
    logic [8:0]  nf;
    logic [11:0] imm12;
    logic [4:0]  rot;

    sts = STS_DONE;
    wr = 1'b0;
    fw = 1'b0;
    rd = 4'd0;
    val = 32'd0;
    nf = flag_word;
    c = flag_word[6];
    case (op)
      OP_MRS_T1: begin
        sysm = w[7:0];
        rd = w[11:8];
        if (is_sp_or_pc(rd) || !sysm_ok(sysm)) sts = STS_UNPRED;
        else if (sysm >= 8'd8) sts = STS_NOT_IMPL;
        else begin
          if (sysm[0]) val = val | {23'd0, excn};
          if (!sysm[2]) begin
            val = val | (flag_view(flag_word) & APSR_NZCVQ_MASK);
            if (dsp_present) val = val | (flag_view(flag_word) & APSR_GE_MASK);
          end
          wr = 1'b1;
        end
      end
      OP_MSR_T1: begin
        sysm = w[7:0];
        mask = w[11:10];
        rn = w[19:16];
        src = read_src(rn, pc);
        if (mask == 2'd0 || (mask != 2'd2 && sysm > 8'd3)) sts = STS_UNPRED;
        else if (is_sp_or_pc(rn) || !sysm_ok(sysm)) sts = STS_UNPRED;
        else if (sysm >= 8'd8) sts = STS_NOT_IMPL;
        else if (!sysm[2]) begin
          // GE needs the DSP option; IPSR/EPSR targets fall through untouched
          if (mask[0] && !dsp_present) sts = STS_UNPRED;
          else begin
            if (mask[0]) nf[3:0] = src[19:16];
            if (mask[1]) nf[8:5] = src[31:28];
            fw = 1'b1;
          end
        end
      end
      OP_MOV_IMM_T1: begin
        rd = {1'b0, w[10:8]};
        val = {24'd0, w[7:0]};
        wr = 1'b1;
        if (!in_it) begin
          nf = nzc_update(nf, val, c);
          fw = 1'b1;
        end
      end
      OP_MOV_IMM_T2: begin
        imm12 = {w[26], w[14:12], w[7:0]};
        b = imm12[7:0];
        rd = w[11:8];
        zero_pattern = 1'b0;
        // Expand the modified immediate: replicate patterns or rotated byte
        if (imm12[11:10] == 2'b00) begin
          co = c;
          zero_pattern = (imm12[9:8] != 2'd0) && (b == 8'd0);
          case (imm12[9:8])
            2'd0:    val = {24'd0, b};
            2'd1:    val = {8'd0, b, 8'd0, b};
            2'd2:    val = {b, 8'd0, b, 8'd0};
            default: val = {b, b, b, b};
          endcase
        end else begin
          rot_base = {24'd0, 1'b1, imm12[6:0]};
          rot = imm12[11:7];
          val = (rot_base >> rot) | (rot_base << (32 - rot));
          co = val[31];
        end
        if (zero_pattern || is_sp_or_pc(rd)) sts = STS_UNPRED;
        else begin
          wr = 1'b1;
          if (w[20]) begin
            nf = nzc_update(nf, val, co);
            fw = 1'b1;
          end
        end
      end
      OP_MOV_IMM_T3: begin
        rd = w[11:8];
        val = {16'd0, w[19:16], w[26], w[14:12], w[7:0]};
        if (is_sp_or_pc(rd)) sts = STS_UNPRED;
        else wr = 1'b1;
      end
      OP_MOV_REG_T1: begin
        rm = w[6:3];
        rd = {w[7], w[2:0]};
        val = read_src(rm, pc);
        if (rd == REG_PC && in_it && !last_it) sts = STS_UNPRED;
        else if (rd == REG_PC) sts = STS_NOT_IMPL;
        else wr = 1'b1;
      end
      OP_MOV_REG_T2: begin
        rm = {1'b0, w[5:3]};
        rd = {1'b0, w[2:0]};
        val = read_src(rm, pc);
        if (in_it) sts = STS_UNPRED;
        else begin
          wr = 1'b1;
          nf = nzc_update(nf, val, c);
          fw = 1'b1;
        end
      end
      default: begin
        rm = w[3:0];
        rd = w[11:8];
        s_form = w[20];
        val = read_src(rm, pc);
        if (s_form && (is_sp_or_pc(rd) || is_sp_or_pc(rm))) sts = STS_UNPRED;
        else if (!s_form && (rd == REG_PC || rm == REG_PC || (rd == REG_SP && rm == REG_SP)))
          sts = STS_UNPRED;
        else begin
          wr = 1'b1;
          if (s_form) begin
            nf = nzc_update(nf, val, c);
            fw = 1'b1;
          end
        end
      end
    endcase

    // Any failing status leaves the state untouched
    if (sts != STS_DONE) begin
      wr = 1'b0;
      fw = 1'b0;
    end
    if (wr) core_regs[rd] = val;
    else begin
      rd = 4'd0;
      val = 32'd0;
    end
    if (fw) flag_word = nf;

    r.status = sts;
    r.reg_write = wr;
    r.reg_index = rd;
    r.reg_value = val;
    r.flags_written = fw;
    r.apsr_value = flag_view(flag_word);
    return r;
  endfunction

  // Track configuration, predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) core_regs[i] = 32'd0;
      flag_word = 9'd0;
      dsp_present = 1'b0;
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) dsp_present = cfg_wdata;
      if (in_valid && in_ready)
        expected_results.push_back(execute_move(op_t'(in_operation), in_instruction,
                                                in_in_it_block, in_last_in_it_block,
                                                in_exception_number, in_pc_value));
      if (out_valid && out_ready) begin
        got.status = out_status;
        got.reg_write = out_reg_write;
        got.reg_index = out_reg_index;
        got.reg_value = out_reg_value;
        got.flags_written = out_flags_written;
        got.apsr_value = out_apsr_value;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result sts=%0d wr=%0b idx=%0d val=%h fw=%0b apsr=%h",
                     $time, got.status, got.reg_write, got.reg_index, got.reg_value,
                     got.flags_written, got.apsr_value);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch expected sts=%0d wr=%0b idx=%0d val=%h fw=%0b apsr=%h",
                        " actual sts=%0d wr=%0b idx=%0d val=%h fw=%0b apsr=%h"},
                       $time, want.status, want.reg_write, want.reg_index, want.reg_value,
                       want.flags_written, want.apsr_value, got.status, got.reg_write,
                       got.reg_index, got.reg_value, got.flags_written, got.apsr_value);
          end
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Move/status unit testbench
// Drives directed and random Thumb MOV/MOVW/MRS/MSR instructions with bursty
// input traffic and a stalling result receiver, switches the DSP option
// between phases, and reports the verdict from the checker's mismatch and outstanding counts.
// ----------------------------------------------------------------------------
module testbench;
  import tmsr_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  op_t         in_operation;
  logic [31:0] in_instruction;
  logic        in_in_it_block;
  logic        in_last_in_it_block;
  logic [8:0]  in_exception_number;
  logic [31:0] in_pc_value;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic        out_reg_write;
  logic [3:0]  out_reg_index;
  logic [31:0] out_reg_value;
  logic        out_flags_written;
  logic [31:0] out_apsr_value;
  int          mismatches;
  int          outstanding;
  int          burst_left;

  thumb_move_and_status_register_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_instruction      (in_instruction),
    .in_in_it_block      (in_in_it_block),
    .in_last_in_it_block (in_last_in_it_block),
    .in_exception_number (in_exception_number),
    .in_pc_value         (in_pc_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_reg_write       (out_reg_write),
    .out_reg_index       (out_reg_index),
    .out_reg_value       (out_reg_value),
    .out_flags_written   (out_flags_written),
    .out_apsr_value      (out_apsr_value)
  );

  move_result_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_instruction      (in_instruction),
    .in_in_it_block      (in_in_it_block),
    .in_last_in_it_block (in_last_in_it_block),
    .in_exception_number (in_exception_number),
    .in_pc_value         (in_pc_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_reg_write       (out_reg_write),
    .out_reg_index       (out_reg_index),
    .out_reg_value       (out_reg_value),
    .out_flags_written   (out_flags_written),
    .out_apsr_value      (out_apsr_value),
    .mismatches          (mismatches),
    .outstanding         (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer one instruction and hold it until the transfer; idle between bursts
  task automatic offer_item(input op_t op, input logic [31:0] word, input logic it,
                            input logic last_it, input logic [8:0] excn,
                            input logic [31:0] pc);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_operation <= op;
    in_instruction <= word;
    in_in_it_block <= it;
    in_last_in_it_block <= last_it;
    in_exception_number <= excn;
    in_pc_value <= pc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and drain every pending result before touching configuration
  task automatic drain;
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_dsp(input logic enable);
    cfg_wdata <= enable;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver: random ready runs and stalls, plus a periodic long hold-off
  initial begin
    int run_len;
    int stall_len;
    int since_hold;
    out_ready = 1'b0;
    since_hold = 0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 25);
      stall_len = $urandom_range(0, 5);
      out_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      if (stall_len != 0) begin
        out_ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
      since_hold += run_len + stall_len;
      if (since_hold >= 900) begin
        out_ready <= 1'b0;
        repeat (160) @(posedge clk);
        since_hold = 0;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    op_t         op;
    logic [31:0] word;
    int          pick;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_MRS_T1;
    in_instruction = 32'd0;
    in_in_it_block = 1'b0;
    in_last_in_it_block = 1'b0;
    in_exception_number = 9'd0;
    in_pc_value = 32'd0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: no DSP option
    set_dsp(1'b0);
    offer_item(OP_MOV_IMM_T1, {16'h0, 5'b00100, 3'd7, 8'hff}, 1'b0, 1'b0, 9'd0, 32'd0);
    offer_item(OP_MOV_IMM_T1, {16'h0, 5'b00100, 3'd1, 8'h00}, 1'b0, 1'b0, 9'd0, 32'd0);
    offer_item(OP_MOV_IMM_T1, {16'h0, 5'b00100, 3'd2, 8'h05}, 1'b1, 1'b1, 9'd0, 32'd0);
    // replicated byte in all four lanes, flags set
    offer_item(OP_MOV_IMM_T2, {5'b11110, 1'b0, 5'b00010, 1'b1, 4'hf, 1'b0, 3'd3, 4'd3, 8'h80},
               1'b0, 1'b0, 9'd0, 32'd0);
    // rotated constant whose top bit becomes the carry
    offer_item(OP_MOV_IMM_T2, {5'b11110, 1'b0, 5'b00010, 1'b1, 4'hf, 1'b0, 3'd4, 4'd4, 8'h00},
               1'b0, 1'b0, 9'd0, 32'd0);
    // replicate pattern with a zero byte
    offer_item(OP_MOV_IMM_T2, {5'b11110, 1'b0, 5'b00010, 1'b0, 4'hf, 1'b0, 3'd1, 4'd5, 8'h00},
               1'b0, 1'b0, 9'd0, 32'd0);
    offer_item(OP_MOV_IMM_T3, {5'b11110, 1'b1, 6'b100100, 4'hf, 1'b0, 3'd7, 4'd4, 8'hff},
               1'b0, 1'b0, 9'd0, 32'd0);
    offer_item(OP_MOV_IMM_T3, {5'b11110, 1'b0, 6'b100100, 4'h1, 1'b0, 3'd0, 4'd13, 8'h01},
               1'b0, 1'b0, 9'd0, 32'd0);
    // read the PC value into r9
    offer_item(OP_MOV_REG_T1, {16'h0, 8'h46, 1'b1, 4'd15, 3'd1}, 1'b0, 1'b0, 9'd0,
               32'hffff_ffff);
    // PC as destination: outside the last IT slot, then plain
    offer_item(OP_MOV_REG_T1, {16'h0, 8'h46, 1'b1, 4'd0, 3'd7}, 1'b1, 1'b0, 9'd0, 32'd0);
    offer_item(OP_MOV_REG_T1, {16'h0, 8'h46, 1'b1, 4'd0, 3'd7}, 1'b0, 1'b0, 9'd0, 32'd0);
    offer_item(OP_MOV_REG_T2, {16'h0, 10'd0, 3'd1, 3'd5}, 1'b0, 1'b0, 9'd0, 32'd0);
    offer_item(OP_MOV_REG_T2, {16'h0, 10'd0, 3'd7, 3'd6}, 1'b1, 1'b1, 9'd0, 32'd0);
    offer_item(OP_MOV_REG_T3, {11'b11101010010, 1'b1, 4'hf, 1'b0, 3'd0, 4'd10, 4'd0, 4'd3},
               1'b0, 1'b0, 9'd0, 32'd0);
    offer_item(OP_MOV_REG_T3, {11'b11101010010, 1'b1, 4'hf, 1'b0, 3'd0, 4'd13, 4'd0, 4'd3},
               1'b0, 1'b0, 9'd0, 32'd0);
    offer_item(OP_MOV_REG_T3, {11'b11101010010, 1'b0, 4'hf, 1'b0, 3'd0, 4'd13, 4'd0, 4'd12},
               1'b0, 1'b0, 9'd0, 32'd0);
    offer_item(OP_MOV_REG_T3, {11'b11101010010, 1'b0, 4'hf, 1'b0, 3'd0, 4'd13, 4'd0, 4'd13},
               1'b0, 1'b0, 9'd0, 32'd0);
    // GE write without the DSP option, then NZCV from all-ones
    offer_item(OP_MSR_T1, {12'hF38, 4'd9, 4'h8, 2'd3, 2'd0, 8'd0}, 1'b0, 1'b0, 9'd0, 32'd0);
    offer_item(OP_MSR_T1, {12'hF38, 4'd9, 4'h8, 2'd2, 2'd0, 8'd0}, 1'b0, 1'b0, 9'd0, 32'd0);
    offer_item(OP_MSR_T1, {12'hF38, 4'd1, 4'h8, 2'd2, 2'd0, 8'd6}, 1'b0, 1'b0, 9'd0, 32'd0);
    offer_item(OP_MRS_T1, {16'hF3EF, 4'h8, 4'd6, 8'd3}, 1'b0, 1'b0, 9'h1ff, 32'd0);
    offer_item(OP_MRS_T1, {16'hF3EF, 4'h8, 4'd6, 8'd8}, 1'b0, 1'b0, 9'd0, 32'd0);
    offer_item(OP_MRS_T1, {16'hF3EF, 4'h8, 4'd6, 8'd4}, 1'b0, 1'b0, 9'd0, 32'd0);
    drain();

    // Directed: DSP option present
    set_dsp(1'b1);
    offer_item(OP_MSR_T1, {12'hF38, 4'd9, 4'h8, 2'd3, 2'd0, 8'd1}, 1'b0, 1'b0, 9'd0, 32'd0);
    offer_item(OP_MRS_T1, {16'hF3EF, 4'h8, 4'd12, 8'd0}, 1'b0, 1'b0, 9'd0, 32'd0);
    offer_item(OP_MSR_T1, {12'hF38, 4'd3, 4'h8, 2'd1, 2'd0, 8'd5}, 1'b0, 1'b0, 9'd0, 32'd0);
    drain();

    // Random phases, alternating the DSP option
    for (int phase = 0; phase < 4; phase++) begin
      set_dsp(phase % 2 == 0);
      for (int n = 0; n < 335; n++) begin
        op = op_t'(3'($urandom_range(0, 7)));
        word = $urandom;
        // steer status register accesses toward legal SYSm and mask values
        if (op == OP_MRS_T1 && $urandom_range(0, 3) != 0) begin
          pick = $urandom_range(0, 13);
          word[7:0] = 8'((pick < 4) ? pick : (pick < 9) ? pick + 1 : pick + 7);
        end
        if (op == OP_MSR_T1 && $urandom_range(0, 3) != 0) begin
          if ($urandom_range(0, 3) != 0) begin
            word[11:10] = 2'($urandom_range(1, 3));
            word[7:0] = 8'($urandom_range(0, 3));
          end else begin
            word[11:10] = 2'd2;
            word[7:0] = 8'($urandom_range(5, 7));
          end
        end
        offer_item(op, word, $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
                   9'($urandom_range(0, 511)), $urandom);
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/tmsr_pkg.sv
hdl/tmsr_front.sv
hdl/tmsr_queue.sv
hdl/tmsr_back.sv
hdl/thumb_move_and_status_register_unit.sv
sim/move_result_checker.sv
sim/testbench.sv
